FILE: sv/bpq_pkg.sv
`default_nettype none

package bpq_pkg;

  localparam int DEPTH = 16;
  localparam int KEY_W = 32;
  localparam int TAG_W = 31;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CFG_W = 5;

  typedef enum logic [1:0] {
    CMD_ENQ  = 2'd0,
    CMD_DEQ  = 2'd1,
    CMD_CLR  = 2'd2,
    CMD_PEEK = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    SEL_HOLD  = 2'd0,
    SEL_NEW   = 2'd1,
    SEL_LEFT  = 2'd2,
    SEL_RIGHT = 2'd3
  } sel_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [TAG_W-1:0]        tag;
  } entry_t;

  typedef struct packed {
    logic en;
    sel_t sel;
  } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: sv/bounded_priority_queue_core.sv
// an accepted transaction is held pending, then loaded into the result registers once the result side is free
// throughput: one transaction per cycle while the result side keeps up
// the sorted row of cells inserts or shifts in the accept cycle, the
// result stage then reads slot 0 and slot count-1
// reset: count zero, capacity 16, no result pending; entries are not cleared
`default_nettype none

module bounded_priority_queue_core (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire  [1:0]                       in_command,
  input  wire  signed [bpq_pkg::KEY_W-1:0] in_key,
  input  wire  [bpq_pkg::TAG_W-1:0]        in_tag,
  output logic                             out_valid,
  input  wire                              out_stall,
  output logic [1:0]                       out_status,
  output logic [bpq_pkg::CNT_W-1:0]        out_count,
  output logic signed [bpq_pkg::KEY_W-1:0] out_min_key,
  output logic [bpq_pkg::TAG_W-1:0]        out_min_tag,
  output logic signed [bpq_pkg::KEY_W-1:0] out_max_key,
  output logic [bpq_pkg::TAG_W-1:0]        out_max_tag,
  output logic                             out_is_empty,
  output logic                             out_is_full,
  input  wire                              cfg_we,
  input  wire  [bpq_pkg::CFG_W-1:0]        cfg_wdata
);

  localparam int DEPTH = bpq_pkg::DEPTH;
  localparam int CNT_W = bpq_pkg::CNT_W;
  localparam int IDX_W = bpq_pkg::IDX_W;

  logic [CNT_W-1:0]       count_r, count_nxt;
  logic [CNT_W-1:0]       capacity_r;
  logic                   pend_r, pend_nxt;
  bpq_pkg::status_t       pend_status_r, pend_status_nxt;
  logic                   out_valid_r, out_valid_nxt;
  bpq_pkg::status_t       out_status_r;
  logic [CNT_W-1:0]       out_count_r;
  bpq_pkg::entry_t        out_min_r, out_max_r;
  logic                   out_is_empty_r, out_is_full_r;

  bpq_pkg::entry_t        new_entry;
  bpq_pkg::entry_t        slot [DEPTH];
  logic [DEPTH-1:0]       below;
  logic [DEPTH:0]         ge;
  bpq_pkg::cell_ctrl_t    ctrl [DEPTH];
  bpq_pkg::cmd_t          cmd;
  logic                   accept;
  logic                   full;
  logic                   reject;
  logic                   insert;
  logic                   res_load;
  logic [IDX_W-1:0]       min_idx;
  logic [CNT_W-1:0]       min_pos;

  assign new_entry.key = in_key;
  assign new_entry.tag = in_tag;
  assign cmd           = bpq_pkg::cmd_t'(in_command);
  assign res_load      = pend_r && (!out_valid_r || !out_stall);
  assign in_stall      = pend_r && out_valid_r && out_stall;
  assign accept        = in_valid && !in_stall;
  assign full          = (count_r >= capacity_r);
  assign reject        = full && ge[0];
  assign insert        = accept && (cmd == bpq_pkg::CMD_ENQ) && !reject;

  // ge marks slots at or after the insertion point
  assign ge[DEPTH] = 1'b1;

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic            ge_left;
      bpq_pkg::entry_t left_entry, right_entry;

      assign ge[gi] = (count_r <= CNT_W'(gi)) || below[gi];

      if (gi == 0) begin : g_first
        assign ge_left    = 1'b0;
        assign left_entry = new_entry;
      end else begin : g_mid
        assign ge_left    = ge[gi-1];
        assign left_entry = slot[gi-1];
      end

      if (gi == DEPTH - 1) begin : g_last
        assign right_entry = new_entry;
      end else begin : g_rest
        assign right_entry = slot[gi+1];
      end

      always_comb begin
        ctrl[gi].en = insert;
        if (full) begin
          if (ge[gi]) begin
            ctrl[gi].sel = bpq_pkg::SEL_HOLD;
          end else if (ge[gi+1]) begin
            ctrl[gi].sel = bpq_pkg::SEL_NEW;
          end else begin
            ctrl[gi].sel = bpq_pkg::SEL_RIGHT;
          end
        end else begin
          if (!ge[gi]) begin
            ctrl[gi].sel = bpq_pkg::SEL_HOLD;
          end else if (!ge_left) begin
            ctrl[gi].sel = bpq_pkg::SEL_NEW;
          end else begin
            ctrl[gi].sel = bpq_pkg::SEL_LEFT;
          end
        end
      end

      bpq_cell u_cell (
        .clk         (clk),
        .ctrl        (ctrl[gi]),
        .new_entry   (new_entry),
        .left_entry  (left_entry),
        .right_entry (right_entry),
        .entry       (slot[gi]),
        .below       (below[gi])
      );
    end
  endgenerate

  always_comb begin
    count_nxt       = count_r;
    pend_status_nxt = pend_status_r;
    pend_nxt        = pend_r && !res_load;
    if (accept) begin
      pend_nxt        = 1'b1;
      pend_status_nxt = bpq_pkg::ST_OK;
      case (cmd)
        bpq_pkg::CMD_ENQ: begin
          if (reject) begin
            pend_status_nxt = bpq_pkg::ST_FULL;
          end else if (!full) begin
            count_nxt = count_r + CNT_W'(1);
          end
        end
        bpq_pkg::CMD_DEQ: begin
          if (count_r == '0) begin
            pend_status_nxt = bpq_pkg::ST_EMPTY;
          end else begin
            count_nxt = count_r - CNT_W'(1);
          end
        end
        bpq_pkg::CMD_CLR: count_nxt = '0;
        default: begin
          if (count_r == '0) begin
            pend_status_nxt = bpq_pkg::ST_EMPTY;
          end
        end
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign min_pos = count_r - CNT_W'(1);
  assign min_idx = min_pos[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r       <= '0;
      capacity_r    <= CNT_W'(DEPTH);
      pend_r        <= 1'b0;
      pend_status_r <= bpq_pkg::ST_OK;
      out_valid_r   <= 1'b0;
    end else begin
      count_r       <= count_nxt;
      pend_r        <= pend_nxt;
      pend_status_r <= pend_status_nxt;
      out_valid_r   <= out_valid_nxt;
      if (cfg_we && (count_r == '0)) begin
        if (cfg_wdata == '0) begin
          capacity_r <= CNT_W'(1);
        end else if (CNT_W'(cfg_wdata) > CNT_W'(DEPTH)) begin
          capacity_r <= CNT_W'(DEPTH);
        end else begin
          capacity_r <= CNT_W'(cfg_wdata);
        end
      end
    end
  end

  // result stage, read from the state left by the pending transaction
  always_ff @(posedge clk) begin
    if (res_load) begin
      out_status_r   <= pend_status_r;
      out_count_r    <= count_r;
      out_is_empty_r <= (count_r == '0);
      out_is_full_r  <= (count_r == capacity_r);
      if (count_r == '0) begin
        out_min_r <= '0;
        out_max_r <= '0;
      end else begin
        out_min_r <= slot[min_idx];
        out_max_r <= slot[0];
      end
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_count    = out_count_r;
  assign out_min_key  = out_min_r.key;
  assign out_min_tag  = out_min_r.tag;
  assign out_max_key  = out_max_r.key;
  assign out_max_tag  = out_max_r.tag;
  assign out_is_empty = out_is_empty_r;
  assign out_is_full  = out_is_full_r;

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= capacity_r)
    else $error("count above capacity");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && cmd == bpq_pkg::CMD_CLR) |=> (count_r == '0))
    else $error("clear left entries");

  a_reject_full: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r && pend_status_r == bpq_pkg::ST_FULL) |-> (count_r == capacity_r))
    else $error("reject while not full");

  a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r && pend_status_r == bpq_pkg::ST_EMPTY) |-> (count_r == '0))
    else $error("empty status with entries held");

  a_min_max: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_is_empty_r) |-> (out_min_r.key <= out_max_r.key))
    else $error("smallest entry above largest");

endmodule

`default_nettype wire

FILE: sv/bpq_cell.sv
`default_nettype none

module bpq_cell (
  input  wire                      clk,
  input  wire bpq_pkg::cell_ctrl_t ctrl,
  input  wire bpq_pkg::entry_t     new_entry,
  input  wire bpq_pkg::entry_t     left_entry,
  input  wire bpq_pkg::entry_t     right_entry,
  output bpq_pkg::entry_t          entry,
  output logic                     below
);

  bpq_pkg::entry_t entry_r;

  // held entry ranks strictly below the incoming one
  always_comb begin
    if (entry_r.key != new_entry.key) begin
      below = (entry_r.key < new_entry.key);
    end else begin
      below = (entry_r.tag < new_entry.tag);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      case (ctrl.sel)
        bpq_pkg::SEL_NEW:   entry_r <= new_entry;
        bpq_pkg::SEL_LEFT:  entry_r <= left_entry;
        bpq_pkg::SEL_RIGHT: entry_r <= right_entry;
        default:            entry_r <= entry_r;
      endcase
    end
  end

  assign entry = entry_r;

endmodule

`default_nettype wire

FILE: bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import bpq_pkg::*;

  localparam int HOLD_CYCLES    = 80;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_ITEMS   = 600;
  localparam int PHASES         = 7;

  typedef struct packed {
    status_t                 status;
    logic [CNT_W-1:0]        count;
    logic signed [KEY_W-1:0] min_key;
    logic [TAG_W-1:0]        min_tag;
    logic signed [KEY_W-1:0] max_key;
    logic [TAG_W-1:0]        max_tag;
    logic                    is_empty;
    logic                    is_full;
  } result_t;

  logic                    clk;
  logic                    rst_n      = 1'b0;
  logic                    in_valid   = 1'b0;
  logic                    in_stall;
  logic [1:0]              in_command = '0;
  logic signed [KEY_W-1:0] in_key     = '0;
  logic [TAG_W-1:0]        in_tag     = '0;
  logic                    out_valid;
  logic                    out_stall  = 1'b0;
  logic [1:0]              out_status;
  logic [CNT_W-1:0]        out_count;
  logic signed [KEY_W-1:0] out_min_key;
  logic [TAG_W-1:0]        out_min_tag;
  logic signed [KEY_W-1:0] out_max_key;
  logic [TAG_W-1:0]        out_max_tag;
  logic                    out_is_empty;
  logic                    out_is_full;
  logic                    cfg_we     = 1'b0;
  logic [CFG_W-1:0]        cfg_wdata  = '0;

  bpq_pkg::entry_t shadow_entries [DEPTH];
  int unsigned     shadow_count    = 0;
  int unsigned     shadow_capacity = DEPTH;
  result_t         awaited_results [$];

  int unsigned mismatches      = 0;
  int unsigned sent_items      = 0;
  int unsigned results_checked = 0;
  int unsigned evictions       = 0;
  int unsigned full_rejects    = 0;
  int unsigned empty_reports   = 0;
  int unsigned capacity_writes = 0;
  int unsigned stalled_cycles  = 0;

  logic        quiet       = 1'b0;
  int unsigned hold_ticket = 0;
  int unsigned hold_seen   = 0;
  int unsigned hold_left   = 0;

  bounded_priority_queue_core dut (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic ranks_lower(bpq_pkg::entry_t held, bpq_pkg::entry_t incoming);
    if (held.key != incoming.key) return $signed(held.key) < $signed(incoming.key);
    return held.tag < incoming.tag;
  endfunction

  function automatic result_t apply_command(cmd_t cmd, logic signed [KEY_W-1:0] key,
                                            logic [TAG_W-1:0] tag);
    result_t         r;
    bpq_pkg::entry_t e;
    int unsigned     pos;
    int unsigned     i;
    r = '0;
    r.status = ST_OK;
    e.key = key;
    e.tag = tag;
    pos = 0;
    case (cmd)
      CMD_ENQ: begin
        while (pos < shadow_count && !ranks_lower(shadow_entries[pos], e)) pos++;
        if (shadow_count >= shadow_capacity) begin
          if (pos == 0) begin
            r.status = ST_FULL;
            full_rejects++;
          end else begin
            // the largest entry drops out of slot 0
            pos--;
            for (i = 0; i < pos; i++) shadow_entries[i] = shadow_entries[i + 1];
            shadow_entries[pos] = e;
            evictions++;
          end
        end else begin
          for (i = shadow_count; i > pos; i--) shadow_entries[i] = shadow_entries[i - 1];
          shadow_entries[pos] = e;
          shadow_count++;
        end
      end
      CMD_DEQ: begin
        if (shadow_count == 0) r.status = ST_EMPTY;
        else shadow_count--;
      end
      CMD_CLR: shadow_count = 0;
      default: begin
        if (shadow_count == 0) r.status = ST_EMPTY;
      end
    endcase
    if (r.status == ST_EMPTY) empty_reports++;
    r.count = CNT_W'(shadow_count);
    if (shadow_count != 0) begin
      r.min_key = shadow_entries[shadow_count - 1].key;
      r.min_tag = shadow_entries[shadow_count - 1].tag;
      r.max_key = shadow_entries[0].key;
      r.max_tag = shadow_entries[0].tag;
    end
    r.is_empty = (shadow_count == 0);
    r.is_full  = (shadow_count == shadow_capacity);
    return r;
  endfunction

  function automatic string describe(result_t r);
    return $sformatf("status %0d count %0d min (%0d, %0d) max (%0d, %0d) empty %0b full %0b",
                     r.status, r.count, r.min_key, r.min_tag, r.max_key, r.max_tag,
                     r.is_empty, r.is_full);
  endfunction

  function automatic void report_mismatch(string why, result_t want, result_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s", $time, why);
      $display("  expected %s", describe(want));
      $display("  observed %s", describe(got));
    end
  endfunction

  function automatic logic signed [KEY_W-1:0] random_key();
    case ($urandom_range(9))
      0:       return {1'b0, {(KEY_W-1){1'b1}}};
      1:       return {1'b1, {(KEY_W-1){1'b0}}};
      2, 3:    return KEY_W'(int'($urandom_range(6)) - 3);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [TAG_W-1:0] random_tag();
    case ($urandom_range(9))
      0:       return {TAG_W{1'b1}};
      1:       return '0;
      2, 3:    return TAG_W'($urandom_range(3));
      default: return TAG_W'($urandom);
    endcase
  endfunction

  task automatic send_command(cmd_t cmd, logic signed [KEY_W-1:0] key, logic [TAG_W-1:0] tag);
    if (!quiet && $urandom_range(99) < 16) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_command <= cmd;
    in_key     <= key;
    in_tag     <= tag;
    do @(posedge clk); while (in_stall);
    awaited_results.push_back(apply_command(cmd, key, tag));
    sent_items++;
  endtask

  task automatic send_random(int unsigned enq_pct);
    cmd_t        cmd;
    int unsigned r;
    r = $urandom_range(99);
    if (r < enq_pct) begin
      cmd = CMD_ENQ;
    end else begin
      r = $urandom_range(19);
      cmd = (r == 0) ? CMD_CLR : (r <= 5) ? CMD_PEEK : CMD_DEQ;
    end
    send_command(cmd, random_key(), random_tag());
  endtask

  task automatic settle_queue();
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(logic [CFG_W-1:0] value);
    settle_queue();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    // the register only takes a new value while the queue holds nothing
    if (shadow_count == 0)
      shadow_capacity = (value == 0) ? 1 : (value > DEPTH) ? DEPTH : value;
    capacity_writes++;
  endtask

  task automatic test_empty_queue();
    send_command(CMD_PEEK, '0, '0);
    send_command(CMD_DEQ, random_key(), random_tag());
  endtask

  task automatic test_sort_order();
    send_command(CMD_ENQ, 0, 5);
    send_command(CMD_ENQ, {1'b0, {(KEY_W-1){1'b1}}}, '0);
    send_command(CMD_ENQ, {1'b1, {(KEY_W-1){1'b0}}}, {TAG_W{1'b1}});
    send_command(CMD_ENQ, 0, {TAG_W{1'b1}});
    send_command(CMD_ENQ, 0, 5);
    send_command(CMD_PEEK, '0, '0);
    send_command(CMD_DEQ, '0, '0);
    send_command(CMD_DEQ, '0, '0);
    send_command(CMD_CLR, '0, '0);
  endtask

  task automatic test_full_queue();
    write_capacity(0);
    send_command(CMD_ENQ, 10, 1);
    send_command(CMD_ENQ, 20, 1);
    send_command(CMD_ENQ, 10, 1);
    send_command(CMD_ENQ, -5, 0);
    write_capacity(3);
    send_command(CMD_PEEK, '0, '0);
    send_command(CMD_CLR, '0, '0);
    write_capacity(3);
    send_command(CMD_ENQ, 7, 2);
    send_command(CMD_ENQ, 7, 9);
    send_command(CMD_ENQ, -1, 4);
    send_command(CMD_ENQ, 100, 0);
    send_command(CMD_ENQ, 7, 5);
  endtask

  task automatic test_backpressure();
    write_capacity(31);
    hold_ticket <= hold_ticket + 1;
    repeat (40) send_random(70);
  endtask

  task automatic test_random_traffic();
    int unsigned caps [PHASES];
    int unsigned p;
    caps = '{16, 1, 5, 31, 0, 9, 16};
    caps[5] = $urandom_range(2, 15);
    for (p = 0; p < PHASES; p++) begin
      if ($urandom_range(2) != 0) send_command(CMD_CLR, '0, '0);
      write_capacity(CFG_W'(caps[p]));
      quiet <= (p == 3);
      repeat (RANDOM_ITEMS / PHASES) send_random(caps[p] >= 9 ? 60 : 50);
    end
    quiet <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (hold_seen != hold_ticket) begin
      hold_seen <= hold_ticket;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !quiet && ($urandom_range(99) < 16);
    end
  end

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      got.status   = status_t'(out_status);
      got.count    = out_count;
      got.min_key  = out_min_key;
      got.min_tag  = out_min_tag;
      got.max_key  = out_max_key;
      got.max_tag  = out_max_tag;
      got.is_empty = out_is_empty;
      got.is_full  = out_is_full;
      results_checked++;
      if (awaited_results.size() == 0) begin
        report_mismatch("result transaction with none outstanding", '0, got);
      end else begin
        want = awaited_results.pop_front();
        if (got !== want) report_mismatch("result transaction differs", want, got);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) stalled_cycles = 0;
    else stalled_cycles++;
    if (stalled_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("** bounded_priority_queue_core: FAILED **");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_queue();
    test_sort_order();
    test_full_queue();
    test_backpressure();
    test_random_traffic();
    settle_queue();
    repeat (6) @(posedge clk);
    if (awaited_results.size() != 0)
      $display("%0d expected results never arrived", awaited_results.size());
    $display("covered %0d commands, %0d results checked, %0d capacity writes incl. clamped",
             sent_items, results_checked, capacity_writes);
    $display("%0d evictions, %0d rejections when full, %0d empty reports, one long hold-off",
             evictions, full_rejects, empty_reports);
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("** bounded_priority_queue_core: PASSED **");
    end else begin
      $display("** bounded_priority_queue_core: FAILED **");
    end
    $finish;
  end

endmodule
